// File: rtl/core/sltsolve_pkg.sv
// Types and constants shared by the sparse lower-triangular solver.
package sltsolve_pkg;
   localparam int DefMaxRows  = 4096;
   localparam int DefFracBits = 16;
   localparam int ColW        = 12;

   typedef struct packed {
      logic [ColW-1:0]    column;
      logic signed [31:0] entry_value;
      logic signed [31:0] rhs_value;
      logic               row_end;
      logic               first_of_system;
   } req_word_type;

   typedef struct packed {
      logic [ColW-1:0]    row_index;
      logic signed [31:0] solution;
      logic               divide_error;
      logic               overflow;
   } rsp_word_type;

   typedef struct packed {
      logic        start;
      logic [63:0] num_mag;
      logic [31:0] den_mag;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quot;
   } div_res_type;
endpackage

// File: rtl/core/sltsolve_ram.sv
// Generic single-port RAM with registered read.
module sltsolve_ram #(
   parameter int Width = 32,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule

// File: rtl/core/sltsolve_div.sv
// Restoring divider, one quotient bit per cycle, 64 by 32 unsigned.
module sltsolve_div
   import sltsolve_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_res_type res
);
   logic [63:0] quot_ff, quot_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [33:0] trial;

   always_comb begin
      quot_in = quot_ff; rem_in = rem_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, quot_ff[63]} - {2'b0, den_ff};
      if (cmd.start) begin
         quot_in = cmd.num_mag; rem_in = '0; den_in = cmd.den_mag;
         cnt_in = 7'd64; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[33]) begin
            rem_in  = trial[32:0];
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[31:0], quot_ff[63]};
            quot_in = {quot_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in; rem_ff <= rem_in; den_ff <= den_in;
   end

   assign res.done = done_ff;
   assign res.quot = quot_ff;
endmodule

// File: rtl/core/sparse_lower_triangular_solve.sv
// Sparse lower-triangular solver, forward substitution over CSR nonzeros.
// An off-diagonal word passes through accept, solution store read, multiply
// and saturating accumulate; a diagonal word passes through accept and divide
// setup, then waits in the output state for the one-bit-per-cycle divider.
// One word is handled at a time; the next request is taken once rsp holds no
// pending word. Columns at or beyond MaxRows read as zero. Store entries never
// written read as undefined.
module sparse_lower_triangular_solve
   import sltsolve_pkg::*;
#(
   parameter int MaxRows  = DefMaxRows,
   parameter int FracBits = DefFracBits
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);
   localparam int AW = $clog2(MaxRows);
   localparam logic signed [63:0] SMax = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SMin = 64'sh8000_0000_0000_0000;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_READ = 6'b000010, S_MUL = 6'b000100,
      S_ACC  = 6'b001000, S_DIV  = 6'b010000, S_OUT = 6'b100000
   } state_type;

   state_type    state_ff, state_in;
   req_word_type w_ff, w_in;
   logic signed [63:0] sum_ff, sum_in, prod_ff, prod_in, num_ff, num_in;
   logic         sovf_ff, sovf_in, inrange_ff, inrange_in;
   logic [AW-1:0] row_ff, row_in;
   logic         rv_ff, rv_in, neg_ff, neg_in, novf_ff, novf_in;
   rsp_word_type rsp_ff, rsp_in;
   logic [31:0]  rd_data;
   logic         wr_en;
   div_cmd_type  dcmd;
   div_res_type  dres;
   logic signed [64:0] acc, nsub;
   logic signed [63:0] rhs_sh;
   logic [63:0]  qm;
   logic         ovfq;

   sltsolve_ram #(.Width(32), .Depth(MaxRows)) u_store (
      .clock, .wr_en, .addr(wr_en ? row_ff : w_in.column[AW-1:0]),
      .wr_data(rsp_in.solution), .rd_data);

   sltsolve_div u_div (.clock, .reset, .cmd(dcmd), .res(dres));

   assign req_stall = (state_ff != S_IDLE) || rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      state_in = state_ff; w_in = w_ff; sum_in = sum_ff; prod_in = prod_ff;
      num_in = num_ff; sovf_in = sovf_ff; row_in = row_ff; rv_in = rv_ff;
      neg_in = neg_ff; novf_in = novf_ff; rsp_in = rsp_ff; wr_en = 1'b0;
      inrange_in = inrange_ff;
      dcmd = '0; qm = dres.quot; ovfq = 1'b0;
      acc = {sum_ff[63], sum_ff} + {prod_ff[63], prod_ff};
      rhs_sh = 64'(signed'(w_ff.rhs_value)) <<< FracBits;
      nsub = {rhs_sh[63], rhs_sh} - {sum_ff[63], sum_ff};
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_valid && !req_stall) begin
            w_in = req_word;
            inrange_in = (32'(req_word.column) < 32'(MaxRows));
            if (req_word.first_of_system) begin
               row_in = '0; sum_in = '0; sovf_in = 1'b0;
            end
            state_in = req_word.row_end ? S_DIV : S_READ;
         end
         S_READ: state_in = S_MUL;
         S_MUL: begin
            prod_in = inrange_ff ? 64'(signed'(w_ff.entry_value)) *
                      64'(signed'(rd_data)) : '0;
            state_in = S_ACC;
         end
         S_ACC: begin
            if (acc[64] != acc[63]) begin
               sum_in = acc[64] ? SMin : SMax; sovf_in = 1'b1;
            end else sum_in = acc[63:0];
            state_in = S_IDLE;
         end
         S_DIV: begin
            novf_in = sovf_ff;
            if (sum_ff == SMin) begin
               num_in = SMax; novf_in = 1'b1;
            end else if (nsub[64] != nsub[63]) begin
               num_in = nsub[64] ? SMin : SMax; novf_in = 1'b1;
            end else num_in = nsub[63:0];
            neg_in = num_in[63] != w_ff.entry_value[31];
            dcmd.start = 1'b1;
            dcmd.num_mag = num_in[63] ? 64'(-num_in) : num_in;
            dcmd.den_mag = w_ff.entry_value[31] ? 32'(-w_ff.entry_value)
                                                : w_ff.entry_value;
            state_in = S_OUT;
         end
         S_OUT: if (dres.done) begin
            rsp_in.row_index = 12'(row_ff);
            rsp_in.divide_error = 1'b0;
            if (w_ff.entry_value == 32'sd0) begin
               rsp_in.divide_error = 1'b1; ovfq = 1'b0;
               rsp_in.solution = num_ff[63] ? 32'h8000_0000 :
                                 (num_ff == '0 ? 32'h0 : 32'h7FFF_FFFF);
               rsp_in.overflow = 1'b0;
            end else begin
               if (!neg_ff) begin
                  if (qm > 64'h7FFF_FFFF) begin
                     qm = 64'h7FFF_FFFF; ovfq = 1'b1;
                  end
                  rsp_in.solution = qm[31:0];
               end else begin
                  if (qm > 64'h8000_0000) begin
                     qm = 64'h8000_0000; ovfq = 1'b1;
                  end
                  rsp_in.solution = 32'(-qm);
               end
               rsp_in.overflow = novf_ff | ovfq;
            end
            wr_en = 1'b1; rv_in = 1'b1;
            row_in = (32'(row_ff) == MaxRows - 1) ? '0 : row_ff + 1'b1;
            sum_in = '0; sovf_in = 1'b0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; sum_ff <= '0; sovf_ff <= 1'b0;
         row_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; sum_ff <= sum_in; sovf_ff <= sovf_in;
         row_ff <= row_in; rv_ff <= rv_in;
      end
      w_ff <= w_in; prod_ff <= prod_in; num_ff <= num_in; neg_ff <= neg_in;
      novf_ff <= novf_in; rsp_ff <= rsp_in; inrange_ff <= inrange_in;
   end

`ifndef SYNTHESIS
   a_div_err_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.divide_error |-> !rsp_word.overflow)
      else $error("divide error with overflow");
   a_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall) else $error("accept while busy");
   a_row_adv: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_word.row_index != 12'(row_ff) || MaxRows == 4096)
      else $error("row counter did not advance");
`endif
endmodule

// File: test/sparse_lower_triangular_solve_checker.sv
`timescale 1ns / 1ps
// Checker for the sparse lower-triangular solver: predicts each solved unknown and compares.
module sparse_lower_triangular_solve_checker
   import sltsolve_pkg::*;
#(
   parameter int MaxRows  = DefMaxRows,
   parameter int FracBits = DefFracBits
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_word,
   output int           errors,
   output int           pending
);
   localparam longint SumMax = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint SumMin = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

   logic [31:0]  unknowns [MaxRows];
   longint       acc_sum;
   int unsigned  solve_row;
   bit           acc_ovf;
   rsp_word_type solved_q [$];

   assign pending = solved_q.size();

   function automatic longint sat_sum(longint a, longint b, inout bit ovf);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         ovf = 1'b1;
         s = a[63] ? SumMin : SumMax;
      end
      return s;
   endfunction

   task automatic take_word(req_word_type w);
      longint       val, rhs, xv, num;
      bit           ovf, derr, neg;
      logic [63:0]  nm, dm, qm;
      logic [31:0]  res;
      rsp_word_type r;
      val = longint'(w.entry_value);
      rhs = longint'(w.rhs_value);
      if (w.first_of_system) begin
         solve_row = 0;
         acc_sum = 0;
         acc_ovf = 1'b0;
      end
      if (!w.row_end) begin
         xv = (w.column < MaxRows) ? longint'(signed'(unknowns[w.column])) : 0;
         acc_sum = sat_sum(acc_sum, val * xv, acc_ovf);
         return;
      end
      ovf = acc_ovf;
      derr = 1'b0;
      if (acc_sum == SumMin) begin
         num = SumMax;
         ovf = 1'b1;
      end else begin
         num = sat_sum(rhs * (longint'(1) << FracBits), -acc_sum, ovf);
      end
      if (val == 0) begin
         derr = 1'b1;
         ovf = 1'b0;
         res = (num > 0) ? 32'h7FFF_FFFF : (num < 0) ? 32'h8000_0000 : 32'h0;
      end else begin
         neg = (num < 0) != (val < 0);
         nm = num[63] ? 64'd0 - num : num;
         dm = val[63] ? 64'd0 - val : val;
         qm = nm / dm;
         if (!neg) begin
            if (qm > 64'h7FFF_FFFF) begin
               qm = 64'h7FFF_FFFF;
               ovf = 1'b1;
            end
            res = qm[31:0];
         end else begin
            if (qm > 64'h8000_0000) begin
               qm = 64'h8000_0000;
               ovf = 1'b1;
            end
            qm = 64'd0 - qm;
            res = qm[31:0];
         end
      end
      unknowns[solve_row % MaxRows] = res;
      r.row_index = solve_row[ColW-1:0];
      r.solution = res;
      r.divide_error = derr;
      r.overflow = ovf;
      solved_q.push_back(r);
      solve_row = (solve_row + 1) % MaxRows;
      acc_sum = 0;
      acc_ovf = 1'b0;
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      rsp_word_type e;
      if (reset) begin
         acc_sum <= 0;
         solve_row <= 0;
         acc_ovf <= 1'b0;
         solved_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (solved_q.size() == 0) begin
               $display("%0t: unexpected word row %0d solution %h", $time,
                        rsp_word.row_index, rsp_word.solution);
               errors++;
            end else begin
               e = solved_q.pop_front();
               if (e.row_index != rsp_word.row_index || e.solution != rsp_word.solution
                   || e.divide_error != rsp_word.divide_error
                   || e.overflow != rsp_word.overflow) begin
                  $display("%0t: mismatch expected row %0d x %h derr %b ovf %b, got row %0d x %h derr %b ovf %b",
                           $time, e.row_index, e.solution, e.divide_error, e.overflow,
                           rsp_word.row_index, rsp_word.solution, rsp_word.divide_error,
                           rsp_word.overflow);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) take_word(req_word);
      end
   end
endmodule

// File: test/sparse_lower_triangular_solve_test.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the sparse lower-triangular solver.
module sparse_lower_triangular_solve_test;
   import sltsolve_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   int           errors, pending;
   int           idle_pct = 0, stall_pct = 0;
   bit           solved [DefMaxRows];
   int           next_row = 0;

   sparse_lower_triangular_solve uut (.*);
   sparse_lower_triangular_solve_checker chk (.*);

   always #5 clock = ~clock;

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_word(int col, logic [31:0] val, logic [31:0] rhs, bit last, bit first);
      req_word_type w;
      w.column = col[ColW-1:0];
      w.entry_value = val;
      w.rhs_value = rhs;
      w.row_end = last;
      w.first_of_system = first;
      if (first) next_row = 0;
      if (last) begin
         solved[next_row] = 1'b1;
         next_row = (next_row + 1) % DefMaxRows;
      end
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_word = w;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic int solved_column();
      int c;
      do c = $urandom_range(DefMaxRows - 1); while (!solved[c]);
      return c;
   endfunction

   function automatic logic [31:0] mixed_value();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(262143) - 131072;
         2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom_range(131071) + 32'h8000;
      endcase
   endfunction

   task automatic random_row();
      int n;
      bit first;
      logic [31:0] diag;
      n = $urandom_range(9) < 7 ? $urandom_range(3) : $urandom_range(8);
      first = ($urandom_range(99) < 5);
      for (int i = 0; i < n; i++) begin
         send_word(solved_column(), mixed_value(), $urandom, 1'b0, first);
         first = ($urandom_range(99) < 3);
      end
      diag = ($urandom_range(99) < 8) ? 32'h0 : mixed_value();
      send_word($urandom_range(4095), diag, mixed_value(), 1'b1, first);
   endtask

   task automatic wait_drained();
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // row 0 saturates positive, row 1 reads it
      send_word(0, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1, 1'b1);
      send_word(0, 32'h8000_0000, 32'h0, 1'b0, 1'b0);
      send_word(4095, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
      // sum driven to the negative limit, zero diagonal
      for (int i = 0; i < 4; i++) send_word(0, 32'h8000_0000, 32'h0, 1'b0, 1'b0);
      send_word(0, 32'h0, 32'h0, 1'b1, 1'b0);
      // positive saturation of the sum
      for (int i = 0; i < 4; i++) send_word(0, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0);
      send_word(0, 32'h0001_0000, 32'h8000_0000, 1'b1, 1'b0);
      send_word(0, 32'h0, 32'h0, 1'b1, 1'b0);
      send_word(0, 32'h0, 32'hFFFF_0000, 1'b1, 1'b0);
      send_word(1, 32'h0001_0000, 32'h0, 1'b0, 1'b0);
      send_word(2, 32'hFFFF_0000, 32'h0003_0000, 1'b1, 1'b0);
      send_word(3, 32'h0000_8000, 32'h0, 1'b0, 1'b0);
      send_word(0, 32'h0, 32'h0, 1'b0, 1'b1);
      send_word(2047, 32'hFFFF_FFFF, 32'h0002_0000, 1'b1, 1'b0);
      wait_drained();

      // run of diagonals with mixed values
      send_word(0, mixed_value(), mixed_value(), 1'b1, 1'b1);
      for (int i = 1; i < 40; i++)
         send_word($urandom_range(4095), mixed_value(), mixed_value(), 1'b1, 1'b0);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 58; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 58; end
            default: begin idle_pct = 22; stall_pct = 22; end
         endcase
         for (int r = 0; r < 60; r++) random_row();
         if (phase == 1) begin
            @(negedge clock);
            req_valid = 1'b0;
            while (pending != 0) @(negedge clock);
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      stall_pct = 0;
      wait_drained();
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

// File: sim.f
rtl/core/sltsolve_pkg.sv
rtl/core/sltsolve_ram.sv
rtl/core/sltsolve_div.sv
rtl/core/sparse_lower_triangular_solve.sv
test/sparse_lower_triangular_solve_checker.sv
test/sparse_lower_triangular_solve_test.sv
